// File: src/fair_share_rate_estimator_top_defines.svh
// Assertion helpers used by the top-level RTL file.
`ifndef FAIR_SHARE_RATE_ESTIMATOR_TOP_DEFINES_SVH
`define FAIR_SHARE_RATE_ESTIMATOR_TOP_DEFINES_SVH

// Consequent checked in the same cycle.
`define FSRE_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// Consequent checked in the next cycle.
`define FSRE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

// File: src/fsre_pkg.sv
package fsre_pkg;

	localparam int EXP_TABLE_SIZE = 256;
	localparam int EXP_IDX_W      = $clog2(EXP_TABLE_SIZE);
	// position = gap * SIZE * 2^16 / (16 * K) = (gap << W_SHIFT) / K
	localparam int W_SHIFT        = EXP_IDX_W + 12;
	localparam int P_W            = EXP_IDX_W + 16;
	localparam int RATE_BITS      = 36;
	localparam int TIME_BITS      = 48;
	localparam int DIV_B_W        = 64;
	localparam int DIV_CNT_W      = 7;
	localparam int ADDR_W         = 5;

	localparam logic [29:0] NS_PER_S = 30'd1000000000;
	localparam logic [16:0] WGT_ONE  = 17'd65536;

	localparam logic [1:0] REG_LINK_RATE       = 2'd0;
	localparam logic [1:0] REG_QUEUE_THRESHOLD = 2'd1;
	localparam logic [1:0] REG_WINDOW_TICKS    = 2'd2;

	typedef logic [16:0] wgt_t;
	typedef wgt_t exp_tab_t [EXP_TABLE_SIZE+1];

	typedef struct packed {
		logic [16:0] pkt_bits;
		logic [35:0] norm_rate;
		logic [47:0] arrival_time;
		logic        was_dropped;
		logic [23:0] queue_bytes;
		logic [35:0] excess_bw;
	} in_item_t;

	typedef struct packed {
		logic [35:0] fair_share;
		logic [35:0] total_rate;
		logic [35:0] enqueued_rate;
		logic        is_congested;
	} out_item_t;

	typedef struct packed {
		logic                 start;
		logic [35:0]          a;
		logic [DIV_B_W-1:0]   b;
		logic [47:0]          c;
		logic [DIV_CNT_W-1:0] iters;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [35:0] q;
	} div_rsp_t;

	// restoring long division, only evaluated while building the table
	function automatic logic [63:0] const_div(logic [63:0] num, logic [63:0] den);
		logic [63:0] q;
		logic [64:0] r;
		q = '0;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[63:0], num[b]};
			if (r >= {1'b0, den}) begin
				r    = r - {1'b0, den};
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// exp(-16*i/SIZE) in Q1.16, Taylor series for the step ratio in Q0.32,
	// then repeated multiplication with round to nearest.
	function automatic exp_tab_t build_exp_tab();
		exp_tab_t    tab;
		logic [63:0] r;
		logic [63:0] term;
		logic [63:0] cur;
		logic [63:0] den;
		logic [63:0] rnd;
		r    = 64'd1 << 32;
		term = 64'd1 << 32;
		for (int n = 1; n <= 24; n++) begin
			den  = 64'(EXP_TABLE_SIZE) * 64'(n);
			term = const_div(term * 64'd16 + (den >> 1), den);
			if ((n & 1) != 0) r = r - term;
			else r = r + term;
		end
		cur = 64'd1 << 32;
		for (int i = 0; i <= EXP_TABLE_SIZE; i++) begin
			rnd    = (cur + 64'd32768) >> 16;
			tab[i] = rnd[16:0];
			cur    = (cur * r + 64'h80000000) >> 32;
		end
		return tab;
	endfunction

	localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

// File: src/fsre_div.sv
// Bit-serial unit: q = floor(a * b' / c), b' = top iters bits of b, one bit of b per cycle, MSB first.
// With a = 1 it is a plain long division of b by c. Quotient saturates.
module fsre_div import fsre_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [35:0]          a_q;
	logic [DIV_B_W-1:0]   b_q;
	logic [47:0]          c_q;
	logic [47:0]          r_q;
	logic [35:0]          q_q;
	logic                 sat_q;

	logic [49:0] r2;
	logic [49:0] rn;
	logic [1:0]  dig;
	logic [37:0] qn;

	always_comb begin
		r2 = {1'b0, r_q, 1'b0} + {14'b0, (b_q[DIV_B_W-1] ? a_q : 36'd0)};
		if (r2 >= {1'b0, c_q, 1'b0}) begin
			rn  = r2 - {1'b0, c_q, 1'b0};
			dig = 2'd2;
		end else if (r2 >= {2'b0, c_q}) begin
			rn  = r2 - {2'b0, c_q};
			dig = 2'd1;
		end else begin
			rn  = r2;
			dig = 2'd0;
		end
		qn = {1'b0, q_q, 1'b0} + {36'b0, dig};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !req.start && busy_q && (cnt_q == DIV_CNT_W'(1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.iters;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q   <= req.a;
			b_q   <= req.b;
			c_q   <= req.c;
			r_q   <= '0;
			q_q   <= '0;
			sat_q <= 1'b0;
		end else if (busy_q) begin
			b_q   <= {b_q[DIV_B_W-2:0], 1'b0};
			r_q   <= rn[47:0];
			q_q   <= qn[35:0];
			sat_q <= sat_q | (qn[37:36] != 2'b00);
		end
	end

	assign rsp.done = done_q;
	assign rsp.q    = sat_q ? '1 : q_q;

endmodule

// File: src/fsre_weight.sv
// Averaging weight from the Q16 table position: linear interpolation
// between two neighboring exp table entries.
module fsre_weight import fsre_pkg::*; (
	input  logic [P_W-1:0] pos,
	output wgt_t           weight
);

	logic [EXP_IDX_W-1:0] idx;
	logic [EXP_IDX_W:0]   idx_nx;
	logic [15:0]          frac;
	wgt_t                 hi;
	wgt_t                 lo;
	logic [32:0]          prod;
	logic [33:0]          rnd;

	always_comb begin
		idx    = pos[P_W-1:16];
		idx_nx = {1'b0, idx} + 1'b1;
		frac   = pos[15:0];
		hi     = EXP_TAB[idx];
		lo     = EXP_TAB[idx_nx];
		if (lo > hi) lo = hi;
		prod   = (hi - lo) * frac;
		rnd    = {1'b0, prod} + 34'd32768;
		weight = hi - rnd[32:16];
	end

endmodule

// File: src/fair_share_rate_estimator_top.sv
// Channel   Handshake                  Payload
// in        in_valid / in_ready        in_data  (in_item_t)
// out       out_valid / out_ready      out_data (out_item_t)
// config    psel penable pwrite pready paddr, pwdata, prdata (64 bit)
//
// An item whose time does not advance goes from PREP straight to DONE. An item
// that advances time uses one shared bit-serial divider for the weight
// position (56 bits, skipped when the gap spans 16 windows or more), both
// instantaneous rates (62 bits each) and, at a congested window end with
// alpha below the enqueued rate, the alpha scaling (36 bits), one bit per cycle.
// Reset clears the estimator state and loads the config defaults; the exp table is a constant, no fill pass.
// A result waits in the output register; the next item is taken meanwhile.
module fair_share_rate_estimator_top import fsre_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  in_item_t          in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output out_item_t         out_data,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [63:0]       pwdata,
	output logic [63:0]       prdata,
	output logic              pready
);

`include "fair_share_rate_estimator_top_defines.svh"

	typedef enum logic [3:0] {
		ST_IDLE, ST_PREP, ST_WDIV, ST_TDIV, ST_TMUL, ST_TSUM,
		ST_EDIV, ST_EMUL, ST_ESUM, ST_ALPHA, ST_MDIV, ST_DONE
	} st_t;

	localparam logic [DIV_CNT_W-1:0] IT_WGT  = DIV_CNT_W'(36 + W_SHIFT);
	localparam logic [DIV_CNT_W-1:0] IT_RATE = DIV_CNT_W'(62);
	localparam logic [DIV_CNT_W-1:0] IT_MD   = DIV_CNT_W'(36);

	// configuration
	logic [35:0] link_q;
	logic [23:0] thr_q;
	logic [31:0] win_q;

	// estimator state
	st_t         state_q;
	in_item_t    itm_q;
	logic [47:0] last_q;
	logic [47:0] ws_q;
	logic [31:0] pt_q;
	logic [31:0] pe_q;
	logic [35:0] avg_tot_q;
	logic [35:0] avg_enq_q;
	logic [35:0] alpha_q;
	logic [35:0] peak_q;
	logic        cong_q;
	logic [47:0] gap_q;
	wgt_t        w_q;
	logic [35:0] inst_q;
	logic [37:0] m1_q;
	logic [37:0] m2_q;
	out_item_t   out_q;
	logic        out_valid_q;
	div_req_t    div_req_q;
	div_rsp_t    div_rsp;

	logic        cfg_wr;
	logic [31:0] k_eff;
	logic [47:0] last1;
	logic [31:0] pt_n;
	logic [31:0] pe_n;
	logic [47:0] gap_n;
	logic [61:0] num_tot;
	logic [61:0] num_enq;
	wgt_t        w_int;
	logic [35:0] avg_sel;
	logic [38:0] m_sum;
	logic [35:0] m_sat;

	logic [35:0] a_n;
	logic [35:0] pk_n;
	logic        cm_n;
	logic [47:0] ws_n;
	logic        need_md;

	function automatic logic [31:0] sat_add32(logic [31:0] a, logic [16:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {16'b0, b};
		return s[32] ? 32'hFFFFFFFF : s[31:0];
	endfunction

	// (a >> 16) * b + round((a & 0xFFFF) * b / 65536)
	function automatic logic [37:0] mul_q16(logic [35:0] a, logic [16:0] b);
		logic [36:0] hi;
		logic [32:0] lp;
		logic [33:0] lr;
		hi = a[35:16] * b;
		lp = a[15:0] * b;
		lr = {1'b0, lp} + 34'd32768;
		return {1'b0, hi} + {20'b0, lr[33:16]};
	endfunction

	fsre_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req_q),
		.rsp    (div_rsp)
	);

	fsre_weight u_weight (
		.pos    (div_rsp.q[P_W-1:0]),
		.weight (w_int)
	);

	// config port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		unique case (paddr[4:3])
			REG_LINK_RATE:       prdata = {28'b0, link_q};
			REG_QUEUE_THRESHOLD: prdata = {40'b0, thr_q};
			REG_WINDOW_TICKS:    prdata = {32'b0, win_q};
			default:             prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_q <= 36'd1000000000;
			thr_q  <= '0;
			win_q  <= 32'd100000000;
		end else if (cfg_wr) begin
			unique case (paddr[4:3])
				REG_LINK_RATE:       link_q <= pwdata[35:0];
				REG_QUEUE_THRESHOLD: thr_q  <= pwdata[23:0];
				REG_WINDOW_TICKS:    win_q  <= pwdata[31:0];
				default: ;
			endcase
		end
	end

	// per item arithmetic
	always_comb begin
		k_eff   = (win_q == '0) ? 32'd1 : win_q;
		last1   = (last_q == '0) ? itm_q.arrival_time : last_q;
		pt_n    = sat_add32(pt_q, itm_q.pkt_bits);
		pe_n    = itm_q.was_dropped ? pe_q : sat_add32(pe_q, itm_q.pkt_bits);
		gap_n   = itm_q.arrival_time - last1;
		num_tot = 62'(pt_q) * 62'(NS_PER_S);
		num_enq = 62'(pe_q) * 62'(NS_PER_S);
		avg_sel = (state_q == ST_TMUL) ? avg_tot_q : avg_enq_q;
		m_sum   = {1'b0, m1_q} + {1'b0, m2_q};
		m_sat   = (m_sum[38:36] != 3'b000) ? '1 : m_sum[35:0];
	end

	// windowed fair share update, done once the averages are final
	always_comb begin
		logic [47:0] t;
		logic        open_win;
		logic        fin;
		t        = itm_q.arrival_time;
		open_win = (t < ws_q) || ((t - ws_q) < {16'b0, k_eff});
		a_n      = alpha_q;
		pk_n     = peak_q;
		cm_n     = cong_q;
		ws_n     = ws_q;
		need_md  = 1'b0;
		fin      = 1'b0;
		if (a_n == '0) begin
			if (itm_q.queue_bytes < thr_q) begin
				if (itm_q.norm_rate > pk_n) pk_n = itm_q.norm_rate;
				fin = 1'b1;
			end else begin
				a_n  = (pk_n == '0) ? {1'b0, link_q[35:1]} : pk_n;
				pk_n = '0;
			end
		end
		if (!fin) begin
			if (avg_tot_q >= itm_q.excess_bw) begin
				if (!cm_n) begin
					cm_n = 1'b1;
					ws_n = t;
				end else if (!open_win) begin
					ws_n = t;
					if (a_n >= avg_enq_q) a_n = itm_q.excess_bw;
					else need_md = 1'b1;
				end
			end else if (cm_n) begin
				cm_n = 1'b0;
				ws_n = t;
				pk_n = '0;
			end else if (open_win) begin
				if (itm_q.norm_rate > pk_n) pk_n = itm_q.norm_rate;
			end else begin
				a_n  = pk_n;
				ws_n = t;
				if (itm_q.queue_bytes < thr_q) a_n = '0;
				else pk_n = '0;
			end
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			itm_q       <= '0;
			last_q      <= '0;
			ws_q        <= '0;
			pt_q        <= '0;
			pe_q        <= '0;
			avg_tot_q   <= '0;
			avg_enq_q   <= '0;
			alpha_q     <= '0;
			peak_q      <= '0;
			cong_q      <= 1'b0;
			gap_q       <= '0;
			w_q         <= '0;
			inst_q      <= '0;
			m1_q        <= '0;
			m2_q        <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
			div_req_q   <= '0;
		end else begin
			// start is a one-cycle pulse; no new request is issued while it is high
			if (div_req_q.start) div_req_q.start <= 1'b0;
			if (out_valid_q && out_ready && state_q != ST_DONE) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						itm_q   <= in_data;
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					pt_q   <= pt_n;
					pe_q   <= pe_n;
					last_q <= last1;
					gap_q  <= gap_n;
					if (itm_q.arrival_time > last1) begin
						// at 16 windows or beyond the weight is zero
						if (gap_n >= {12'b0, k_eff, 4'b0}) begin
							w_q       <= '0;
							div_req_q <= '{start: 1'b1, a: 36'd1,
								b: {62'(pt_n) * 62'(NS_PER_S), 2'b0},
								c: gap_n, iters: IT_RATE};
							state_q   <= ST_TDIV;
						end else begin
							div_req_q <= '{start: 1'b1, a: 36'd1,
								b: {gap_n[35:0], 28'b0},
								c: {16'b0, k_eff}, iters: IT_WGT};
							state_q   <= ST_WDIV;
						end
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_WDIV: begin
					if (div_rsp.done) begin
						w_q       <= w_int;
						div_req_q <= '{start: 1'b1, a: 36'd1, b: {num_tot, 2'b0},
							c: gap_q, iters: IT_RATE};
						state_q   <= ST_TDIV;
					end
				end
				ST_TDIV: begin
					if (div_rsp.done) begin
						inst_q  <= div_rsp.q;
						state_q <= ST_TMUL;
					end
				end
				ST_TMUL, ST_EMUL: begin
					m1_q    <= mul_q16(inst_q, WGT_ONE - w_q);
					m2_q    <= mul_q16(avg_sel, w_q);
					state_q <= (state_q == ST_TMUL) ? ST_TSUM : ST_ESUM;
				end
				ST_TSUM: begin
					avg_tot_q <= m_sat;
					div_req_q <= '{start: 1'b1, a: 36'd1, b: {num_enq, 2'b0},
						c: gap_q, iters: IT_RATE};
					state_q   <= ST_EDIV;
				end
				ST_EDIV: begin
					if (div_rsp.done) begin
						inst_q  <= div_rsp.q;
						state_q <= ST_EMUL;
					end
				end
				ST_ESUM: begin
					avg_enq_q <= m_sat;
					pt_q      <= '0;
					pe_q      <= '0;
					last_q    <= itm_q.arrival_time;
					state_q   <= ST_ALPHA;
				end
				ST_ALPHA: begin
					alpha_q <= a_n;
					peak_q  <= pk_n;
					cong_q  <= cm_n;
					ws_q    <= ws_n;
					if (need_md) begin
						div_req_q <= '{start: 1'b1, a: a_n,
							b: {itm_q.excess_bw, 28'b0},
							c: {12'b0, avg_enq_q}, iters: IT_MD};
						state_q   <= ST_MDIV;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_MDIV: begin
					if (div_rsp.done) begin
						alpha_q <= (div_rsp.q > itm_q.excess_bw) ?
							itm_q.excess_bw : div_rsp.q;
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_q       <= '{fair_share: alpha_q, total_rate: avg_tot_q,
							enqueued_rate: avg_enq_q, is_congested: cong_q};
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`FSRE_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "second item taken while busy")
	`FSRE_ASSERT_SAME(a_div_done_state, div_rsp.done, state_q == ST_WDIV || state_q == ST_TDIV || state_q == ST_EDIV || state_q == ST_MDIV, "divider result with no waiting state")
	`FSRE_ASSERT_SAME(a_weight_range, state_q == ST_TDIV, w_q <= WGT_ONE, "weight above one")

endmodule
